// File: hdl/tqwsa_pkg.sv
// ----------------------------------------------------------------------------
// tqwsa_pkg
// Shared types and constants of the two-queue weighted service arbiter.
// ----------------------------------------------------------------------------
package tqwsa_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TAG_WIDTH_DEF   = 16;
  localparam int unsigned OPCODE_W        = 2;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned LIMIT_W         = 4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQ_COMMON   = 2'd0,
    OP_ENQ_PRIORITY = 2'd1,
    OP_SERVE        = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PRIORITY = 2'd0,
    ST_COMMON   = 2'd1,
    ST_WAIT     = 2'd2,
    ST_DROPPED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic respond;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_result;
  } dp_stat_t;

endpackage

// File: hdl/two_queue_weighted_service_arbiter_core.sv
// ----------------------------------------------------------------------------
// two_queue_weighted_service_arbiter_core
// Burst-limited arbiter over a priority and a common client tag queue.
// ----------------------------------------------------------------------------
// Serves and dropped enqueues strobe done_o in the response state after the
//   execute state; stored enqueues give none. Execute is the one state where no
//   transaction is taken; busy_o is high there and one port per queue is used.
// The receiver cannot stall; each result is valid for one cycle only.
// Reset: queues empty, burst counter zero, burst limit 3; memory not cleared.
module two_queue_weighted_service_arbiter_core #(
  parameter int unsigned QUEUE_DEPTH = tqwsa_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_WIDTH   = tqwsa_pkg::TAG_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [tqwsa_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [TAG_WIDTH-1:0]           client_tag_i,
  output logic                           done_o,
  output logic [TAG_WIDTH-1:0]           served_tag_o,
  output logic [tqwsa_pkg::STATUS_W-1:0] status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tqwsa_pkg::LIMIT_W-1:0]  cfg_data_i
);
  import tqwsa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  tqwsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  tqwsa_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TAG_WIDTH(TAG_WIDTH)) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .opcode_i     (opcode_i),
    .client_tag_i (client_tag_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .served_tag_o (served_tag_o),
    .status_o     (status_o),
    .done_o       (done_o)
  );

endmodule

// File: hdl/tqwsa_fifo.sv
// ----------------------------------------------------------------------------
// tqwsa_fifo
// Tag FIFO with a memory store, head and tail pointers and an entry count.
// ----------------------------------------------------------------------------
module tqwsa_fifo #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == CNT_FULL);
  assign rd_data_o = rd_data_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d  = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (pop_i) begin
      head_d  = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_q] <= data_i;
    end
    if (pop_i) begin
      rd_data_q <= mem[head_q];
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && pop_i)) else $error("push and pop in one cycle");
  a_count_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q)) else $error("pointers disagree");

endmodule

// File: hdl/tqwsa_ctrl.sv
// ----------------------------------------------------------------------------
// tqwsa_ctrl
// Controller: accept a transaction, execute it, present its result if it has one.
// ----------------------------------------------------------------------------
module tqwsa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  tqwsa_pkg::dp_stat_t  stat_i,
  output tqwsa_pkg::ctrl_cmd_t cmd_o,
  output logic                 busy_o
);
  import tqwsa_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q != S_EXEC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = stat_i.has_result ? S_RESP : S_IDLE;
      end
      S_RESP: begin
        state_d = accept ? S_EXEC : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load    = accept;
    cmd_o.exec    = (state_q == S_EXEC);
    cmd_o.respond = (state_q == S_RESP);
    busy_o        = (state_q == S_EXEC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/tqwsa_datapath.sv
// ----------------------------------------------------------------------------
// tqwsa_datapath
// Datapath: command registers, both queues, burst counter and result path.
// ----------------------------------------------------------------------------
module tqwsa_datapath #(
  parameter int unsigned QUEUE_DEPTH = tqwsa_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_WIDTH   = tqwsa_pkg::TAG_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tqwsa_pkg::ctrl_cmd_t           cmd_i,
  output tqwsa_pkg::dp_stat_t            stat_o,
  input  logic [tqwsa_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [TAG_WIDTH-1:0]           client_tag_i,
  input  logic                           cfg_valid_i,
  input  logic [tqwsa_pkg::LIMIT_W-1:0]  cfg_data_i,
  output logic [TAG_WIDTH-1:0]           served_tag_o,
  output logic [tqwsa_pkg::STATUS_W-1:0] status_o,
  output logic                           done_o
);
  import tqwsa_pkg::*;

  logic [OPCODE_W-1:0]  op_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic [LIMIT_W-1:0]   burst_q, burst_d;
  status_e              status_q, status_d;

  logic push_p, push_c, pop_p, pop_c;
  logic p_empty, p_full, c_empty, c_full;
  logic [TAG_WIDTH-1:0] p_data, c_data;
  logic is_serve, is_drop;

  always_comb begin
    is_serve = 1'b0;
    is_drop  = 1'b0;
    unique case (op_q)
      OP_ENQ_COMMON:   is_drop  = c_full;
      OP_ENQ_PRIORITY: is_drop  = p_full;
      OP_SERVE:        is_serve = 1'b1;
      default: ;
    endcase
  end

  assign stat_o.has_result = is_serve || is_drop;

  always_comb begin
    push_p   = 1'b0;
    push_c   = 1'b0;
    pop_p    = 1'b0;
    pop_c    = 1'b0;
    burst_d  = burst_q;
    status_d = ST_DROPPED;
    if (cmd_i.exec) begin
      if (is_serve) begin
        priority if (c_empty && !p_empty) begin
          pop_p    = 1'b1;
          status_d = ST_PRIORITY;
        end else if (p_empty) begin
          burst_d  = '0;
          pop_c    = !c_empty;
          status_d = c_empty ? ST_WAIT : ST_COMMON;
        end else if (burst_q < limit_q) begin
          burst_d  = burst_q + 1'b1;
          pop_p    = 1'b1;
          status_d = ST_PRIORITY;
        end else begin
          burst_d  = '0;
          pop_c    = 1'b1;
          status_d = ST_COMMON;
        end
      end else begin
        push_c = (op_q == OP_ENQ_COMMON) && !c_full;
        push_p = (op_q == OP_ENQ_PRIORITY) && !p_full;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      burst_q <= '0;
    end else begin
      if (cfg_valid_i) limit_q <= cfg_data_i;
      burst_q <= burst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      tag_q <= client_tag_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
    end
  end

  tqwsa_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH(TAG_WIDTH)) u_prio_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_p),
    .data_i    (tag_q),
    .pop_i     (pop_p),
    .rd_data_o (p_data),
    .empty_o   (p_empty),
    .full_o    (p_full)
  );

  tqwsa_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH(TAG_WIDTH)) u_common_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_c),
    .data_i    (tag_q),
    .pop_i     (pop_c),
    .rd_data_o (c_data),
    .empty_o   (c_empty),
    .full_o    (c_full)
  );

  always_comb begin
    unique case (status_q)
      ST_PRIORITY: served_tag_o = p_data;
      ST_COMMON:   served_tag_o = c_data;
      default:     served_tag_o = '0;
    endcase
  end

  assign status_o = status_q;
  assign done_o   = cmd_i.respond;

endmodule
